// ----- rtl/ptts_pkg.sv -----
// Shared types, constants and codes for the periodic task tick scheduler.
`timescale 1ns / 1ps
`default_nettype none

package ptts_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  localparam int OPC_W  = 3;
  localparam int SLOT_W = 4;
  localparam int PER_W  = 8;
  localparam int STAT_W = 2;

  localparam logic [OPC_W-1:0] OPC_TICK    = 3'd0;
  localparam logic [OPC_W-1:0] OPC_CREATE  = 3'd1;
  localparam logic [OPC_W-1:0] OPC_DELETE  = 3'd2;
  localparam logic [OPC_W-1:0] OPC_SUSPEND = 3'd3;
  localparam logic [OPC_W-1:0] OPC_RESUME  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SLOT_ERR  = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRED  = 1'b1;

  typedef enum logic [2:0] {
    TBL_NONE,
    TBL_STEP,
    TBL_CREATE,
    TBL_DELETE,
    TBL_SUSPEND,
    TBL_RESUME
  } tbl_op_e;

  typedef struct packed {
    tbl_op_e          op;
    logic [IDX_W-1:0] idx;
    logic [PER_W-1:0] period;
    logic [PER_W-1:0] delay;
  } tbl_req_t;

  typedef struct packed {
    logic used;
    logic fire;
  } tbl_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/ptts_slot_table.sv -----
// Task slot table with the shared countdown decrement and zero-compare unit.
`timescale 1ns / 1ps
`default_nettype none

module ptts_slot_table (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ptts_pkg::tbl_req_t req_i,
  output ptts_pkg::tbl_rsp_t      rsp_o
);

  logic                      used_q      [ptts_pkg::TASK_SLOTS];
  logic                      running_q   [ptts_pkg::TASK_SLOTS];
  logic [ptts_pkg::PER_W-1:0] period_q    [ptts_pkg::TASK_SLOTS];
  logic [ptts_pkg::PER_W-1:0] countdown_q [ptts_pkg::TASK_SLOTS];

  logic                      rd_used;
  logic                      rd_running;
  logic [ptts_pkg::PER_W-1:0] rd_period;
  logic [ptts_pkg::PER_W-1:0] rd_count;
  logic                      count_zero;
  logic [ptts_pkg::PER_W-1:0] count_next;

  assign rd_used    = used_q[req_i.idx];
  assign rd_running = running_q[req_i.idx];
  assign rd_period  = period_q[req_i.idx];
  assign rd_count   = countdown_q[req_i.idx];

  // Shared unit: one compare and one decrement serve every slot in turn.
  assign count_zero = (rd_count == '0);
  assign count_next = count_zero ? rd_period : (rd_count - ptts_pkg::PER_W'(1));

  assign rsp_o.used = rd_used;
  assign rsp_o.fire = rd_used & rd_running & count_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ptts_pkg::TASK_SLOTS; i++) begin
        used_q[i]      <= 1'b0;
        running_q[i]   <= 1'b0;
        period_q[i]    <= '0;
        countdown_q[i] <= '0;
      end
    end else begin
      case (req_i.op)
        ptts_pkg::TBL_STEP: begin
          if (rd_used && rd_running) begin
            countdown_q[req_i.idx] <= count_next;
          end
        end
        ptts_pkg::TBL_CREATE: begin
          if (!rd_used) begin
            used_q[req_i.idx]      <= 1'b1;
            running_q[req_i.idx]   <= 1'b1;
            period_q[req_i.idx]    <= req_i.period;
            countdown_q[req_i.idx] <= req_i.delay;
          end
        end
        ptts_pkg::TBL_DELETE: begin
          if (rd_used) begin
            used_q[req_i.idx]      <= 1'b0;
            running_q[req_i.idx]   <= 1'b0;
            period_q[req_i.idx]    <= '0;
            countdown_q[req_i.idx] <= '0;
          end
        end
        ptts_pkg::TBL_SUSPEND: begin
          if (rd_used) begin
            running_q[req_i.idx] <= 1'b0;
          end
        end
        ptts_pkg::TBL_RESUME: begin
          if (rd_used) begin
            running_q[req_i.idx] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/periodic_task_tick_scheduler.sv -----
// Top level: command sequencer, tick walk over the slot table, result register.
// Tick: busy through the walk and flush states, one slot walked per cycle through
//   the shared countdown unit; each fire waits for the next, the final one carries last.
// Create, delete, suspend, resume: busy in the command state, status result registered from it.
// Opcodes above resume are dropped with no result and no busy cycle.
// Reset clears all slots to empty; results are strobed for one cycle and never stall.
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_tick_scheduler (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ptts_pkg::OPC_W-1:0]   opcode_i,
  input  wire logic [ptts_pkg::SLOT_W-1:0]  slot_i,
  input  wire logic [ptts_pkg::PER_W-1:0]   period_i,
  input  wire logic [ptts_pkg::PER_W-1:0]   first_delay_i,
  output logic                              result_valid_o,
  output logic                              result_kind_o,
  output logic [ptts_pkg::STAT_W-1:0]       status_o,
  output logic [ptts_pkg::SLOT_W-1:0]       fired_slot_o,
  output logic                              last_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMD   = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  localparam logic [ptts_pkg::IDX_W-1:0] LAST_IDX =
    ptts_pkg::IDX_W'(ptts_pkg::TASK_SLOTS - 1);

  logic [1:0] state_q, state_d;
  logic [ptts_pkg::IDX_W-1:0] walk_q, walk_d;
  logic pend_q, pend_d;
  logic [ptts_pkg::IDX_W-1:0] pend_idx_q, pend_idx_d;

  logic [ptts_pkg::OPC_W-1:0]  cmd_op_q;
  logic [ptts_pkg::SLOT_W-1:0] cmd_slot_q;
  logic [ptts_pkg::PER_W-1:0]  cmd_period_q;
  logic [ptts_pkg::PER_W-1:0]  cmd_delay_q;

  logic                        out_valid_d, out_kind_d, out_last_d;
  logic [ptts_pkg::STAT_W-1:0] out_status_d;
  logic [ptts_pkg::SLOT_W-1:0] out_slot_d;

  logic accept;
  logic in_range;
  ptts_pkg::tbl_req_t tbl_req;
  ptts_pkg::tbl_rsp_t tbl_rsp;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start & ~busy;
  assign in_range = ({1'b0, cmd_slot_q} < (ptts_pkg::SLOT_W + 1)'(ptts_pkg::TASK_SLOTS));

  ptts_slot_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp)
  );

  always_comb begin
    state_d    = state_q;
    walk_d     = walk_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;

    tbl_req.op     = ptts_pkg::TBL_NONE;
    tbl_req.idx    = walk_q;
    tbl_req.period = cmd_period_q;
    tbl_req.delay  = cmd_delay_q;

    out_valid_d  = 1'b0;
    out_kind_d   = ptts_pkg::KIND_STATUS;
    out_status_d = ptts_pkg::STAT_OK;
    out_slot_d   = '0;
    out_last_d   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == ptts_pkg::OPC_TICK) begin
            state_d = ST_WALK;
            walk_d  = '0;
            pend_d  = 1'b0;
          end else if (opcode_i <= ptts_pkg::OPC_RESUME) begin
            state_d = ST_CMD;
          end
        end
      end
      ST_CMD: begin
        tbl_req.idx = cmd_slot_q[ptts_pkg::IDX_W-1:0];
        out_valid_d = 1'b1;
        out_last_d  = 1'b1;
        if (!in_range) begin
          out_status_d = ptts_pkg::STAT_BAD_INDEX;
        end else begin
          case (cmd_op_q)
            ptts_pkg::OPC_CREATE:  tbl_req.op = ptts_pkg::TBL_CREATE;
            ptts_pkg::OPC_DELETE:  tbl_req.op = ptts_pkg::TBL_DELETE;
            ptts_pkg::OPC_SUSPEND: tbl_req.op = ptts_pkg::TBL_SUSPEND;
            ptts_pkg::OPC_RESUME:  tbl_req.op = ptts_pkg::TBL_RESUME;
            default:               tbl_req.op = ptts_pkg::TBL_NONE;
          endcase
          if (cmd_op_q == ptts_pkg::OPC_CREATE) begin
            out_status_d = tbl_rsp.used ? ptts_pkg::STAT_SLOT_ERR : ptts_pkg::STAT_OK;
          end else begin
            out_status_d = tbl_rsp.used ? ptts_pkg::STAT_OK : ptts_pkg::STAT_SLOT_ERR;
          end
        end
        state_d = ST_IDLE;
      end
      ST_WALK: begin
        tbl_req.op = ptts_pkg::TBL_STEP;
        // Hold one fire back so the final one can carry last.
        if (tbl_rsp.fire) begin
          if (pend_q) begin
            out_valid_d = 1'b1;
            out_kind_d  = ptts_pkg::KIND_FIRED;
            out_slot_d  = ptts_pkg::SLOT_W'(pend_idx_q);
          end
          pend_d     = 1'b1;
          pend_idx_d = walk_q;
        end
        if (walk_q == LAST_IDX) begin
          state_d = ST_FLUSH;
        end else begin
          walk_d = walk_q + ptts_pkg::IDX_W'(1);
        end
      end
      ST_FLUSH: begin
        if (pend_q) begin
          out_valid_d = 1'b1;
          out_kind_d  = ptts_pkg::KIND_FIRED;
          out_slot_d  = ptts_pkg::SLOT_W'(pend_idx_q);
          out_last_d  = 1'b1;
        end
        pend_d  = 1'b0;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      walk_q         <= '0;
      pend_q         <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      walk_q         <= walk_d;
      pend_q         <= pend_d;
      result_valid_o <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q    <= pend_idx_d;
    result_kind_o <= out_kind_d;
    status_o      <= out_status_d;
    fired_slot_o  <= out_slot_d;
    last_o        <= out_last_d;
    if (accept) begin
      cmd_op_q     <= opcode_i;
      cmd_slot_q   <= slot_i;
      cmd_period_q <= period_i;
      cmd_delay_q  <= first_delay_i;
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb_periodic_task_tick_scheduler.sv -----
// Self-checking testbench for the periodic task tick scheduler: directed and random commands.
`timescale 1ns / 1ps

typedef struct packed {
  logic                            kind;
  logic [ptts_pkg::STAT_W-1:0]     status;
  logic [ptts_pkg::SLOT_W-1:0]     slot;
  logic                            last;
} sched_result_t;

class scheduler_scoreboard;
  bit                             used_q      [ptts_pkg::TASK_SLOTS];
  bit                             running_q   [ptts_pkg::TASK_SLOTS];
  logic [ptts_pkg::PER_W-1:0]     period_q    [ptts_pkg::TASK_SLOTS];
  logic [ptts_pkg::PER_W-1:0]     countdown_q [ptts_pkg::TASK_SLOTS];
  sched_result_t                  awaited_q[$];
  int unsigned                    failures;

  function new();
    for (int i = 0; i < ptts_pkg::TASK_SLOTS; i++) begin
      used_q[i]      = 1'b0;
      running_q[i]   = 1'b0;
      period_q[i]    = '0;
      countdown_q[i] = '0;
    end
    failures = 0;
  endfunction

  function int unsigned outstanding();
    return awaited_q.size();
  endfunction

  // Update the table for one accepted transaction and queue the results it causes.
  function void note_command(logic [ptts_pkg::OPC_W-1:0] op,
                             logic [ptts_pkg::SLOT_W-1:0] idx,
                             logic [ptts_pkg::PER_W-1:0] per,
                             logic [ptts_pkg::PER_W-1:0] delay);
    sched_result_t               res;
    logic [ptts_pkg::STAT_W-1:0] st;
    int                          fired_n;
    fired_n = 0;
    st      = ptts_pkg::STAT_OK;
    if (op == ptts_pkg::OPC_TICK) begin
      for (int i = 0; i < ptts_pkg::TASK_SLOTS; i++) begin
        if (used_q[i] && running_q[i]) begin
          if (countdown_q[i] == '0) begin
            res = '{ptts_pkg::KIND_FIRED, ptts_pkg::STAT_OK, i[ptts_pkg::SLOT_W-1:0], 1'b0};
            awaited_q.push_back(res);
            fired_n++;
            countdown_q[i] = period_q[i];
          end else begin
            countdown_q[i] = countdown_q[i] - 1'b1;
          end
        end
      end
      if (fired_n > 0) awaited_q[awaited_q.size()-1].last = 1'b1;
      return;
    end
    if (op > ptts_pkg::OPC_RESUME) return;

    if (idx >= ptts_pkg::TASK_SLOTS) begin
      st = ptts_pkg::STAT_BAD_INDEX;
    end else if (op == ptts_pkg::OPC_CREATE) begin
      if (used_q[idx]) begin
        st = ptts_pkg::STAT_SLOT_ERR;
      end else begin
        used_q[idx]      = 1'b1;
        running_q[idx]   = 1'b1;
        period_q[idx]    = per;
        countdown_q[idx] = delay;
      end
    end else if (!used_q[idx]) begin
      st = ptts_pkg::STAT_SLOT_ERR;
    end else if (op == ptts_pkg::OPC_DELETE) begin
      used_q[idx]      = 1'b0;
      running_q[idx]   = 1'b0;
      period_q[idx]    = '0;
      countdown_q[idx] = '0;
    end else if (op == ptts_pkg::OPC_SUSPEND) begin
      running_q[idx] = 1'b0;
    end else begin
      running_q[idx] = 1'b1;
    end
    res = '{ptts_pkg::KIND_STATUS, st, '0, 1'b1};
    awaited_q.push_back(res);
  endfunction

  function void check_result(sched_result_t act);
    sched_result_t exp;
    if (awaited_q.size() == 0) begin
      $display("%0t: unexpected result kind=%0d status=%0d slot=%0d last=%0d",
               $time, act.kind, act.status, act.slot, act.last);
      failures++;
      return;
    end
    exp = awaited_q.pop_front();
    if (act !== exp) begin
      $display("%0t: result mismatch expected kind=%0d status=%0d slot=%0d last=%0d",
               $time, exp.kind, exp.status, exp.slot, exp.last,
               ", actual kind=%0d status=%0d slot=%0d last=%0d",
               act.kind, act.status, act.slot, act.last);
      failures++;
    end
  endfunction
endclass

module tb_periodic_task_tick_scheduler;
  import ptts_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 125;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [OPC_W-1:0]    opcode_i = OPC_TICK;
  logic [SLOT_W-1:0]   slot_i = '0;
  logic [PER_W-1:0]    period_i = '0;
  logic [PER_W-1:0]    first_delay_i = '0;
  logic                result_valid_o;
  logic                result_kind_o;
  logic [STAT_W-1:0]   status_o;
  logic [SLOT_W-1:0]   fired_slot_o;
  logic                last_o;

  scheduler_scoreboard sb;
  int                  quiet_cycles = 0;

  periodic_task_tick_scheduler DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .slot_i         (slot_i),
    .period_i       (period_i),
    .first_delay_i  (first_delay_i),
    .result_valid_o (result_valid_o),
    .result_kind_o  (result_kind_o),
    .status_o       (status_o),
    .fired_slot_o   (fired_slot_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Sample both handshakes on the edge, ahead of any update the edge triggers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_command(opcode_i, slot_i, period_i, first_delay_i);
      if (result_valid_o)
        sb.check_result('{result_kind_o, status_o, fired_slot_o, last_o});
      if ((start && !busy) || result_valid_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // Hold start until the transaction is taken; start stays high for a back-to-back transaction.
  task automatic send_cmd(input logic [OPC_W-1:0] op, input logic [SLOT_W-1:0] idx,
                          input logic [PER_W-1:0] per, input logic [PER_W-1:0] delay);
    start         <= 1'b1;
    opcode_i      <= op;
    slot_i        <= idx;
    period_i      <= per;
    first_delay_i <= delay;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_for(input int unsigned n);
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Hold off until every queued result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  initial begin
    logic [OPC_W-1:0]  op;
    logic [SLOT_W-1:0] idx;
    logic [PER_W-1:0]  per;
    logic [PER_W-1:0]  delay;
    int unsigned       sel;
    int unsigned       burst_left;
    int unsigned       sent;

    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty table, extremes, every error status, ignored opcodes, full fan-out tick.
    send_cmd(OPC_TICK,    4'd0,  8'd0,   8'd0);
    send_cmd(OPC_CREATE,  4'd0,  8'd0,   8'd0);
    send_cmd(OPC_CREATE,  4'd7,  8'd255, 8'd255);
    send_cmd(OPC_CREATE,  4'd0,  8'd3,   8'd3);
    send_cmd(OPC_CREATE,  4'd8,  8'd255, 8'd255);
    send_cmd(OPC_DELETE,  4'd15, 8'd0,   8'd0);
    send_cmd(OPC_SUSPEND, 4'd9,  8'd0,   8'd0);
    send_cmd(OPC_TICK,    4'd0,  8'd0,   8'd0);
    send_cmd(OPC_SUSPEND, 4'd0,  8'd0,   8'd0);
    send_cmd(OPC_TICK,    4'd0,  8'd0,   8'd0);
    send_cmd(OPC_RESUME,  4'd0,  8'd0,   8'd0);
    send_cmd(OPC_RESUME,  4'd0,  8'd0,   8'd0);
    send_cmd(OPC_SUSPEND, 4'd3,  8'd0,   8'd0);
    send_cmd(OPC_DELETE,  4'd3,  8'd0,   8'd0);
    send_cmd(OPC_RESUME,  4'd3,  8'd0,   8'd0);
    for (int i = 5; i < 8; i++) send_cmd(i[OPC_W-1:0], 4'd15, 8'd255, 8'd255);
    send_cmd(OPC_DELETE,  4'd7,  8'd0,   8'd0);
    for (int i = 1; i < TASK_SLOTS; i++) send_cmd(OPC_CREATE, i[SLOT_W-1:0], 8'd0, 8'd0);
    send_cmd(OPC_TICK,    4'd0,  8'd0,   8'd0);
    drain();

    // Random: tick-heavy mix with short periods so that slots fire often.
    sent       = 0;
    burst_left = $urandom_range(1, 12);
    while (sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 45)      op = OPC_TICK;
      else if (sel < 63) op = OPC_CREATE;
      else if (sel < 76) op = OPC_DELETE;
      else if (sel < 86) op = OPC_SUSPEND;
      else if (sel < 96) op = OPC_RESUME;
      else               op = OPC_W'($urandom_range(5, 7));
      idx   = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(8, 15))
                                          : SLOT_W'($urandom_range(0, TASK_SLOTS-1));
      per   = ($urandom_range(0, 3) == 0) ? PER_W'($urandom_range(0, 255))
                                          : PER_W'($urandom_range(0, 5));
      delay = ($urandom_range(0, 3) == 0) ? PER_W'($urandom_range(0, 255))
                                          : PER_W'($urandom_range(0, 5));
      send_cmd(op, idx, per, delay);
      if (op <= OPC_RESUME) sent++;

      if (sent % 50 == 49) begin
        drain();
      end else if (--burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 15));
      end
    end

    drain();
    repeat (TASK_SLOTS + 4) @(posedge clk_i);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
